### design/ppp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg: shared constants and types for the pinhole point projection
// Register map codes, field widths and divider pipeline depth.
// ----------------------------------------------------------------------------
package ppp_pkg;

   // register file geometry (64-bit registers at 8-byte spacing)
   localparam int ADDR_W    = 6;
   localparam int DATA_W    = 64;
   localparam int ROT_W     = 48;
   localparam int COORD_W   = 32;

   // camera coordinate width after rounding to Q16.16
   localparam int CAM_W     = 36;
   // exact focal times camera coordinate product width
   localparam int PROD_W    = 67;
   // quotient bits worked out; anything at or above 2^DIV_STEPS saturates anyway
   localparam int DIV_STEPS = 34;

   typedef enum logic [2:0] {
      REG_ROT_X   = 3'd0,
      REG_ROT_Y   = 3'd1,
      REG_ROT_Z   = 3'd2,
      REG_TRANS_X = 3'd3,
      REG_TRANS_Y = 3'd4,
      REG_TRANS_Z = 3'd5,
      REG_FOCAL   = 3'd6,
      REG_CENTER  = 3'd7
   } reg_idx_type;

   localparam logic [ROT_W-1:0]  ROT_X_RESET  = 48'h0000_0000_4000;
   localparam logic [ROT_W-1:0]  ROT_Y_RESET  = 48'h0000_4000_0000;
   localparam logic [ROT_W-1:0]  ROT_Z_RESET  = 48'h4000_0000_0000;
   localparam logic [DATA_W-1:0] FOCAL_RESET  = 64'h0001_0000_0001_0000;

endpackage

### design/pinhole_point_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_point_projection: rigid pose, perspective divide and intrinsics
// Projects one Q16.16 world point per cycle into saturated Q16.16 pixels.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_point_x/y/z, req_last_in            start high, busy low
//  response  rsp_pixel_u/v, rsp_depth_clamped,       rsp_valid, one cycle
//            rsp_saturated, rsp_last_out
//  csr       psel penable pwrite paddr pwdata ...    apb, pready tied high
//
//  one transaction per clock; busy is never raised
//  8 stages of capture, pose, rounding, multiply and overflow check, then
//  one stage per quotient bit of the 34-bit restoring divider, then the
//  output register; reset clears the valid bits and loads the identity pose
//  the receiver cannot stall, so the pipeline always advances
// ----------------------------------------------------------------------------
module pinhole_point_projection
   import ppp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request
   input  logic                     start,
   output logic                     busy,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_point_z,
   input  logic                     req_last_in,
   // response
   output logic                     rsp_valid,
   output logic signed [COORD_W-1:0] rsp_pixel_u,
   output logic signed [COORD_W-1:0] rsp_pixel_v,
   output logic                     rsp_depth_clamped,
   output logic                     rsp_saturated,
   output logic                     rsp_last_out,
   // configuration
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [ADDR_W-1:0]        paddr,
   input  logic [DATA_W-1:0]        pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   // ---------------------------------------------------------------- csr
   logic [ROT_W-1:0]   rot_ff [3];
   logic [COORD_W-1:0] trans_ff [3];
   logic [DATA_W-1:0]  focal_ff;
   logic [DATA_W-1:0]  center_ff;
   reg_idx_type        csr_idx;

   assign pready  = 1'b1;
   assign busy    = 1'b0;
   assign csr_idx = reg_idx_type'(paddr[ADDR_W-1:3]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0]   <= ROT_X_RESET;
         rot_ff[1]   <= ROT_Y_RESET;
         rot_ff[2]   <= ROT_Z_RESET;
         trans_ff[0] <= '0;
         trans_ff[1] <= '0;
         trans_ff[2] <= '0;
         focal_ff    <= FOCAL_RESET;
         center_ff   <= '0;
      end else if (psel && penable && pwrite && pready) begin
         unique case (csr_idx)
            REG_ROT_X:   rot_ff[0]   <= pwdata[ROT_W-1:0];
            REG_ROT_Y:   rot_ff[1]   <= pwdata[ROT_W-1:0];
            REG_ROT_Z:   rot_ff[2]   <= pwdata[ROT_W-1:0];
            REG_TRANS_X: trans_ff[0] <= pwdata[COORD_W-1:0];
            REG_TRANS_Y: trans_ff[1] <= pwdata[COORD_W-1:0];
            REG_TRANS_Z: trans_ff[2] <= pwdata[COORD_W-1:0];
            REG_FOCAL:   focal_ff    <= pwdata;
            REG_CENTER:  center_ff   <= pwdata;
            default:     ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_idx)
         REG_ROT_X:   prdata = DATA_W'(rot_ff[0]);
         REG_ROT_Y:   prdata = DATA_W'(rot_ff[1]);
         REG_ROT_Z:   prdata = DATA_W'(rot_ff[2]);
         REG_TRANS_X: prdata = DATA_W'(trans_ff[0]);
         REG_TRANS_Y: prdata = DATA_W'(trans_ff[1]);
         REG_TRANS_Z: prdata = DATA_W'(trans_ff[2]);
         REG_FOCAL:   prdata = focal_ff;
         REG_CENTER:  prdata = center_ff;
         default:     prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- valids
   logic [6:0] v_ff;     // stages 1 to 7
   logic       dv_v_ff [DIV_STEPS+1];
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         dv_v_ff[0]   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v_ff         <= {v_ff[5:0], start && !busy};
         dv_v_ff[0]   <= v_ff[6];
         rsp_valid_ff <= dv_v_ff[DIV_STEPS];
      end
   end

   // ---------------------------------------------------------------- stage 1: capture
   logic signed [COORD_W-1:0] s1_pt_ff [3];
   logic [6:0] last_ff;   // stages 1 to 7

   always_ff @(posedge clock) begin
      s1_pt_ff[0] <= req_point_x;
      s1_pt_ff[1] <= req_point_y;
      s1_pt_ff[2] <= req_point_z;
      last_ff     <= {last_ff[5:0], req_last_in};
   end

   // ---------------------------------------------------------------- stage 2: rotation products
   logic signed [47:0] s2_prod_in [3][3];
   logic signed [47:0] s2_prod_ff [3][3];

   always_comb begin
      logic signed [47:0] r_ext;
      logic signed [47:0] p_ext;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            r_ext = {{32{rot_ff[r][16*c+15]}}, rot_ff[r][16*c +: 16]};
            p_ext = {{16{s1_pt_ff[c][COORD_W-1]}}, s1_pt_ff[c]};
            s2_prod_in[r][c] = r_ext * p_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_prod_ff <= s2_prod_in;
   end

   // ---------------------------------------------------------------- stage 3: partial row sums
   logic signed [48:0] s3_a_ff [3];
   logic signed [48:0] s3_b_ff [3];

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         s3_a_ff[r] <= {s2_prod_ff[r][0][47], s2_prod_ff[r][0]}
                     + {s2_prod_ff[r][1][47], s2_prod_ff[r][1]};
         s3_b_ff[r] <= {s2_prod_ff[r][2][47], s2_prod_ff[r][2]}
                     + {{3{trans_ff[r][COORD_W-1]}}, trans_ff[r], 14'd0}
                     + 49'sd8192;
      end
   end

   // ---------------------------------------------------------------- stage 4: round to q16.16
   logic signed [CAM_W-1:0] s4_cam_ff [3];

   always_ff @(posedge clock) begin
      logic signed [49:0] sum;
      for (int r = 0; r < 3; r++) begin
         sum = {s3_a_ff[r][48], s3_a_ff[r]} + {s3_b_ff[r][48], s3_b_ff[r]};
         s4_cam_ff[r] <= sum[49:14];
      end
   end

   // ---------------------------------------------------------------- stage 5: zero depth, magnitudes
   logic [COORD_W-1:0] s5_af_ff [2];
   logic [CAM_W-1:0]   s5_an_ff [2];
   logic [CAM_W-1:0]   s5_ad_ff;
   logic [1:0]         s5_neg_ff;
   logic [2:0]         clamp_ff;   // stages 5 to 7

   always_ff @(posedge clock) begin
      logic [CAM_W-1:0]   d;
      logic [COORD_W-1:0] f;
      logic [CAM_W-1:0]   n;
      d = (s4_cam_ff[2] == '0) ? CAM_W'(1) : s4_cam_ff[2];
      s5_ad_ff <= d[CAM_W-1] ? -d : d;
      for (int a = 0; a < 2; a++) begin
         f = focal_ff[COORD_W*a +: COORD_W];
         n = s4_cam_ff[a];
         s5_af_ff[a]  <= f[COORD_W-1] ? -f : f;
         s5_an_ff[a]  <= n[CAM_W-1] ? -n : n;
         s5_neg_ff[a] <= f[COORD_W-1] ^ n[CAM_W-1] ^ d[CAM_W-1];
      end
      clamp_ff <= {clamp_ff[1:0], (s4_cam_ff[2] == '0)};
   end

   // ---------------------------------------------------------------- stage 6: split products
   logic [49:0]      s6_pl_ff [2];
   logic [49:0]      s6_ph_ff [2];
   logic [CAM_W-1:0] s6_ad_ff;
   logic [1:0]       s6_neg_ff;

   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         s6_pl_ff[a] <= 50'(s5_af_ff[a]) * 50'(s5_an_ff[a][17:0]);
         s6_ph_ff[a] <= 50'(s5_af_ff[a]) * 50'(s5_an_ff[a][CAM_W-1:18]);
      end
      s6_ad_ff  <= s5_ad_ff;
      s6_neg_ff <= s5_neg_ff;
   end

   // ---------------------------------------------------------------- stage 7: full product
   logic [PROD_W-1:0] s7_p_ff [2];
   logic [CAM_W-1:0]  s7_ad_ff;
   logic [1:0]        s7_neg_ff;

   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         s7_p_ff[a] <= PROD_W'(s6_pl_ff[a]) + (PROD_W'(s6_ph_ff[a]) << 18);
      end
      s7_ad_ff  <= s6_ad_ff;
      s7_neg_ff <= s6_neg_ff;
   end

   // ---------------------------------------------------------------- divider pipeline
   // index 0 is stage 8 (overflow check), index k+1 follows quotient step k
   logic [CAM_W-2:0]     dv_rem_ff [DIV_STEPS+1][2];
   logic [DIV_STEPS-1:0] dv_lo_ff  [DIV_STEPS+1][2];
   logic [DIV_STEPS-1:0] dv_q_ff   [DIV_STEPS+1][2];
   logic [1:0]           dv_big_ff [DIV_STEPS+1];
   logic [1:0]           dv_neg_ff [DIV_STEPS+1];
   logic [CAM_W-1:0]     dv_ad_ff  [DIV_STEPS+1];
   logic                 dv_clamp_ff [DIV_STEPS+1];
   logic                 dv_last_ff  [DIV_STEPS+1];

   // stage 8: quotient too large when the top bits already reach the divisor
   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         dv_big_ff[0][a] <= CAM_W'(s7_p_ff[a][PROD_W-1:DIV_STEPS]) >= s7_ad_ff;
         dv_rem_ff[0][a] <= (CAM_W-1)'(s7_p_ff[a][PROD_W-1:DIV_STEPS]);
         dv_lo_ff[0][a]  <= s7_p_ff[a][DIV_STEPS-1:0];
         dv_q_ff[0][a]   <= '0;
      end
      dv_neg_ff[0]   <= s7_neg_ff;
      dv_ad_ff[0]    <= s7_ad_ff;
      dv_clamp_ff[0] <= clamp_ff[2];
      dv_last_ff[0]  <= last_ff[6];
   end

   // one restoring step per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [CAM_W-2:0]     rem_in [2];
      logic [DIV_STEPS-1:0] q_in   [2];

      always_comb begin
         logic [CAM_W-1:0] trial;
         for (int a = 0; a < 2; a++) begin
            trial = {dv_rem_ff[k][a], dv_lo_ff[k][a][DIV_STEPS-1-k]};
            q_in[a] = dv_q_ff[k][a];
            if (trial >= dv_ad_ff[k]) begin
               rem_in[a] = (CAM_W-1)'(trial - dv_ad_ff[k]);
               q_in[a][DIV_STEPS-1-k] = 1'b1;
            end else begin
               rem_in[a] = (CAM_W-1)'(trial);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         dv_rem_ff[k+1]   <= rem_in;
         dv_q_ff[k+1]     <= q_in;
         dv_lo_ff[k+1]    <= dv_lo_ff[k];
         dv_big_ff[k+1]   <= dv_big_ff[k];
         dv_neg_ff[k+1]   <= dv_neg_ff[k];
         dv_ad_ff[k+1]    <= dv_ad_ff[k];
         dv_clamp_ff[k+1] <= dv_clamp_ff[k];
         dv_last_ff[k+1]  <= dv_last_ff[k];
      end
   end

   // ---------------------------------------------------------------- output: sign, offset, clip
   logic [COORD_W-1:0] pix_in [2];
   logic [1:0]         sat_in;

   always_comb begin
      logic [DIV_STEPS:0]   mag;
      logic signed [DIV_STEPS+2:0] sum;
      for (int a = 0; a < 2; a++) begin
         mag = dv_big_ff[DIV_STEPS][a] ? {1'b1, {DIV_STEPS{1'b0}}}
                                       : {1'b0, dv_q_ff[DIV_STEPS][a]};
         sum = dv_neg_ff[DIV_STEPS][a] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
         sum = sum + (DIV_STEPS+3)'($signed(center_ff[COORD_W*a +: COORD_W]));
         if (sum > (DIV_STEPS+3)'(64'sh7FFF_FFFF)) begin
            pix_in[a] = {1'b0, {(COORD_W-1){1'b1}}};
            sat_in[a] = 1'b1;
         end else if (sum < -(DIV_STEPS+3)'(64'sh8000_0000)) begin
            pix_in[a] = {1'b1, {(COORD_W-1){1'b0}}};
            sat_in[a] = 1'b1;
         end else begin
            pix_in[a] = sum[COORD_W-1:0];
            sat_in[a] = 1'b0;
         end
      end
   end

   logic [COORD_W-1:0] rsp_u_ff, rsp_v_ff;
   logic rsp_clamp_ff, rsp_sat_ff, rsp_last_ff;

   always_ff @(posedge clock) begin
      rsp_u_ff     <= pix_in[0];
      rsp_v_ff     <= pix_in[1];
      rsp_sat_ff   <= |sat_in;
      rsp_clamp_ff <= dv_clamp_ff[DIV_STEPS];
      rsp_last_ff  <= dv_last_ff[DIV_STEPS];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_u       = rsp_u_ff;
   assign rsp_pixel_v       = rsp_v_ff;
   assign rsp_depth_clamped = rsp_clamp_ff;
   assign rsp_saturated     = rsp_sat_ff;
   assign rsp_last_out      = rsp_last_ff;

endmodule
